>>> rtl/hdp_pkg.sv
// ----------------------------------------------------------------------------
// DEFLATE header parser package
// Shared types, field kind codes and the fixed tables of the header format.
// ----------------------------------------------------------------------------
`default_nettype none

package hdp_pkg;

    // Field kind codes, also used as the parse stage numbers.
    localparam logic [2:0] KIND_BFINAL = 3'd0;
    localparam logic [2:0] KIND_BTYPE  = 3'd1;
    localparam logic [2:0] KIND_HLIT   = 3'd2;
    localparam logic [2:0] KIND_HDIST  = 3'd3;
    localparam logic [2:0] KIND_HCLEN  = 3'd4;
    localparam logic [2:0] KIND_LENGTH = 3'd5;
    localparam logic [2:0] KIND_TRUNC  = 3'd6;

    localparam logic [4:0] BTYPE_DYNAMIC = 5'd2;
    localparam logic [5:0] LEN_BIAS      = 6'd4;
    localparam logic [4:0] LAST_POS      = 5'd18;

    // Results one byte can cause, and the width of a count of them.
    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned IDX_W       = 2;

    // Parser state carried from byte to byte.
    typedef struct packed {
        logic [6:0] bit_pos;
        logic [2:0] stage;
        logic [4:0] accum;
        logic [2:0] taken;
        logic [4:0] lcount;
        logic [3:0] hclen;
        logic       finished;
    } t_hdr_state;

    // One result item.
    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] value;
        logic [4:0] symbol;
        logic [4:0] position;
        logic       header_done;
        logic       not_dynamic;
        logic [6:0] end_offset;
        logic       last;
    } t_hdr_result;

    typedef t_hdr_result t_result_batch [MAX_RESULTS];

    // Bit width of the field read in each stage.
    function automatic logic [2:0] stage_width(input logic [2:0] stage);
        logic [2:0] w;
        unique case (stage)
            KIND_BFINAL: w = 3'd1;
            KIND_BTYPE:  w = 3'd2;
            KIND_HLIT:   w = 3'd5;
            KIND_HDIST:  w = 3'd5;
            KIND_HCLEN:  w = 3'd4;
            default:     w = 3'd3;
        endcase
        return w;
    endfunction

    // Permuted order of the code-length alphabet symbols.
    function automatic logic [4:0] len_order(input logic [4:0] pos);
        logic [4:0] s;
        unique case (pos)
            5'd0:    s = 5'd16;
            5'd1:    s = 5'd17;
            5'd2:    s = 5'd18;
            5'd3:    s = 5'd0;
            5'd4:    s = 5'd8;
            5'd5:    s = 5'd7;
            5'd6:    s = 5'd9;
            5'd7:    s = 5'd6;
            5'd8:    s = 5'd10;
            5'd9:    s = 5'd5;
            5'd10:   s = 5'd11;
            5'd11:   s = 5'd4;
            5'd12:   s = 5'd12;
            5'd13:   s = 5'd3;
            5'd14:   s = 5'd13;
            5'd15:   s = 5'd2;
            5'd16:   s = 5'd14;
            5'd17:   s = 5'd1;
            default: s = 5'd15;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hdp_byte_step.sv
// ----------------------------------------------------------------------------
// DEFLATE header parser byte step
// Consumes the eight bits of one byte and produces the next parser state
// together with the results that the byte completes.
// ----------------------------------------------------------------------------
`default_nettype none

module hdp_byte_step
    import hdp_pkg::*;
(
    input  var t_hdr_state    i_state,
    input  wire [7:0]         i_byte,
    input  wire               i_start,
    input  wire               i_end,
    output t_hdr_state        o_state,
    output t_result_batch     o_results,
    output logic [CNT_W-1:0]  o_count
);

    // Walk the byte bit by bit, least significant first.
    always_comb begin
        t_hdr_state    st;
        t_result_batch res;
        logic [CNT_W-1:0] n;
        logic [2:0]    stg;
        logic [2:0]    wid;
        logic [4:0]    pos;
        logic [5:0]    lc_next;
        logic [5:0]    lc_need;
        logic          done;
        t_hdr_result   r;

        st = i_start ? '0 : i_state;
        n  = '0;
        // Working values start from zero so nothing is held between passes.
        stg     = '0;
        wid     = '0;
        pos     = '0;
        lc_next = '0;
        lc_need = '0;
        done    = 1'b0;
        r       = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res[k] = '0;
        end

        for (int i = 0; i < 8; i++) begin
            if (!st.finished) begin
                stg = (st.stage <= KIND_LENGTH) ? st.stage : KIND_LENGTH;
                wid = stage_width(stg);
                st.accum   = st.accum | ({4'b0, i_byte[i]} << st.taken);
                st.taken   = st.taken + 3'd1;
                st.bit_pos = st.bit_pos + 7'd1;

                if (st.taken >= wid) begin
                    r   = '0;
                    pos = (st.lcount <= LAST_POS) ? st.lcount : LAST_POS;
                    lc_next = {1'b0, st.lcount} + 6'd1;
                    lc_need = {2'b0, st.hclen} + LEN_BIAS;
                    done    = (lc_next >= lc_need);
                    if (stg == KIND_BTYPE && st.accum != BTYPE_DYNAMIC) begin
                        // Stored or fixed block: the header ends here.
                        r.kind        = KIND_BTYPE;
                        r.value       = st.accum;
                        r.header_done = 1'b1;
                        r.not_dynamic = 1'b1;
                        r.end_offset  = st.bit_pos;
                        st.finished   = 1'b1;
                    end else if (stg < KIND_LENGTH) begin
                        r.kind  = stg;
                        r.value = st.accum;
                        if (stg == KIND_HCLEN) begin
                            st.hclen = st.accum[3:0];
                        end
                        st.stage = stg + 3'd1;
                    end else begin
                        // One code-length-code length.
                        r.kind        = KIND_LENGTH;
                        r.value       = st.accum;
                        r.symbol      = len_order(pos);
                        r.position    = pos;
                        r.header_done = done;
                        r.end_offset  = done ? st.bit_pos : 7'd0;
                        st.lcount     = st.lcount + 5'd1;
                        if (done) begin
                            st.finished = 1'b1;
                        end
                    end
                    if (n < CNT_W'(MAX_RESULTS)) begin
                        res[n[IDX_W-1:0]] = r;
                        n = n + 1'b1;
                    end
                    st.accum = '0;
                    st.taken = '0;
                end
            end
        end

        // Stream ran out before the header was complete.
        if (i_end && !st.finished) begin
            r       = '0;
            r.kind  = KIND_TRUNC;
            r.value = st.accum;
            if (n < CNT_W'(MAX_RESULTS)) begin
                res[n[IDX_W-1:0]] = r;
                n = n + 1'b1;
            end
            st.finished = 1'b1;
        end

        // Flag the final result of this byte.
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res[k].last = (CNT_W'(k + 1) == n);
        end

        o_state   = st;
        o_results = res;
        o_count   = n;
    end

endmodule

`default_nettype wire

>>> rtl/hdp_out_buf.sv
// ----------------------------------------------------------------------------
// DEFLATE header parser result buffer
// Holds the results of one byte and hands them out one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module hdp_out_buf
    import hdp_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,
    input  var t_result_batch i_results,
    input  wire [CNT_W-1:0]   i_count,
    output logic              o_room,
    output logic              o_valid,
    input  wire               i_ready,
    output t_hdr_result       o_result
);

    t_hdr_result      r_entries [MAX_RESULTS];
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic             w_take;
    logic             w_drained;

    // The batch empties when its final entry is taken.
    assign o_valid   = (r_count != '0);
    assign w_take    = o_valid && i_ready;
    assign w_drained = w_take && (({1'b0, r_idx} + 1'b1) == r_count);
    assign o_room    = !o_valid || w_drained;
    assign o_result  = r_entries[r_idx];

    // Batch control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_count <= i_count;
            r_idx   <= '0;
        end else if (w_drained) begin
            r_count <= '0;
            r_idx   <= '0;
        end else if (w_take) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Batch payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                r_entries[k] <= i_results[k];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/deflate_dynamic_header_parser.sv
// ----------------------------------------------------------------------------
// DEFLATE dynamic block header parser
// Reads the block header of a raw DEFLATE stream byte by byte and reports
// every header field, including each code-length-code length with its symbol.
// ----------------------------------------------------------------------------
// The parser takes one stream byte per cycle while its result buffer has room
// and decodes all eight of its bits in that same cycle. Each byte yields zero
// to four results, which wait in a small result buffer and leave one per cycle
// on the master side while tready is high; the next byte is taken in the cycle
// the last buffered result is taken. Set tuser to 1 on a byte to restart
// parsing at its bit 0, and tlast to mark the final available byte; a header
// that is still incomplete then ends in a truncated result. After the header
// is finished, bytes are dropped without results until the next restart.
`default_nettype none

module deflate_dynamic_header_parser
    import hdp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    // Byte stream in.
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  wire [7:0]  i_s_tdata,   // stream_byte
    input  wire [0:0]  i_s_tuser,   // block_start
    input  wire        i_s_tlast,   // stream_end
    // Header fields out.
    output logic       o_m_tvalid,
    input  wire        i_m_tready,
    // field_value[4:0], length_symbol[9:5], length_position[14:10],
    // header_done[15], not_dynamic[16], end_bit_offset[23:17]
    output logic [23:0] o_m_tdata,
    output logic [2:0]  o_m_tuser,  // field_kind
    output logic        o_m_tlast   // last_of_item
);

    t_hdr_state       r_state;
    t_hdr_state       n_state;
    t_result_batch    w_results;
    logic [CNT_W-1:0] w_count;
    logic             w_room;
    logic             w_accept;
    t_hdr_result      w_out;

    assign o_s_tready = w_room;
    assign w_accept   = i_s_tvalid && w_room;

    // Decode of the incoming byte.
    hdp_byte_step u_step (
        .i_state   (r_state),
        .i_byte    (i_s_tdata),
        .i_start   (i_s_tuser[0]),
        .i_end     (i_s_tlast),
        .o_state   (n_state),
        .o_results (w_results),
        .o_count   (w_count)
    );

    // Parser state advances on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // Results of the byte, handed out one at a time.
    hdp_out_buf u_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_accept),
        .i_results (w_results),
        .i_count   (w_count),
        .o_room    (w_room),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_result  (w_out)
    );

    // Pack the result fields onto the master side.
    assign o_m_tdata = {w_out.end_offset, w_out.not_dynamic, w_out.header_done,
                        w_out.position, w_out.symbol, w_out.value};
    assign o_m_tuser = w_out.kind;
    assign o_m_tlast = w_out.last;

endmodule

`default_nettype wire

>>> dv/hdp_field_checker.sv
// ----------------------------------------------------------------------------
// DEFLATE header field checker
// Watches both stream channels of the header parser. It decodes every
// accepted byte with its own copy of the parser state, queues the header
// fields that byte must produce, and compares each field taken from the
// master side against the oldest one still waiting.
// ----------------------------------------------------------------------------
module hdp_field_checker
    import hdp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    // Byte stream side.
    input  wire        i_s_tvalid,
    input  wire        i_s_tready,
    input  wire [7:0]  i_s_tdata,   // stream_byte
    input  wire [0:0]  i_s_tuser,   // block_start
    input  wire        i_s_tlast,   // stream_end
    // Header field side.
    input  wire        i_m_tvalid,
    input  wire        i_m_tready,
    // field_value[4:0], length_symbol[9:5], length_position[14:10],
    // header_done[15], not_dynamic[16], end_bit_offset[23:17]
    input  wire [23:0] i_m_tdata,
    input  wire [2:0]  i_m_tuser,   // field_kind
    input  wire        i_m_tlast,   // last_of_item
    output int         o_fail_count,
    output int         o_pending
);

    // Bits per field, indexed by parse stage.
    localparam logic [0:5][2:0] FIELD_WIDTH = {3'd1, 3'd2, 3'd5, 3'd5, 3'd4, 3'd3};
    // Code-length alphabet symbols in the order their lengths are sent.
    localparam logic [0:18][4:0] SYMBOL_ORDER = {
        5'd16, 5'd17, 5'd18, 5'd0, 5'd8, 5'd7, 5'd9, 5'd6, 5'd10, 5'd5,
        5'd11, 5'd4, 5'd12, 5'd3, 5'd13, 5'd2, 5'd14, 5'd1, 5'd15
    };
    localparam int REPORT_LINES = 40;

    // Parser state mirrored from the byte stream.
    logic [6:0] bit_pos;
    logic [2:0] parse_stage;
    logic [4:0] field_bits;
    logic [2:0] bits_taken;
    logic [4:0] lengths_done;
    logic [3:0] hclen_raw;
    logic       header_closed;

    t_hdr_result expected_fields[$];
    int          fail_total = 0;
    int          pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    task automatic report_mismatch(input string msg);
        if (fail_total < REPORT_LINES) begin
            $display("%0t: header field mismatch: %s", $time, msg);
        end
        fail_total++;
    endtask

    task automatic clear_parser();
        bit_pos       = '0;
        parse_stage   = KIND_BFINAL;
        field_bits    = '0;
        bits_taken    = '0;
        lengths_done  = '0;
        hclen_raw     = '0;
        header_closed = 1'b0;
    endtask

    function automatic void add_expected(input logic [2:0] kind, input logic [4:0] value,
                                         input logic [4:0] symbol,
                                         input logic [4:0] position, input logic done,
                                         input logic not_dyn, input logic [6:0] end_off);
        t_hdr_result r;
        r.kind        = kind;
        r.value       = value;
        r.symbol      = symbol;
        r.position    = position;
        r.header_done = done;
        r.not_dynamic = not_dyn;
        r.end_offset  = end_off;
        r.last        = 1'b0;
        expected_fields.push_back(r);
    endfunction

    // Walk the eight bits of one byte, least significant first, and queue
    // every header field that completes along the way.
    task automatic decode_header_byte(input logic [7:0] data, input logic restart,
                                      input logic at_end);
        int         first;
        int         i;
        logic [2:0] stg;
        logic [2:0] wid;
        logic [4:0] pos;
        logic       last_len;
        first = expected_fields.size();
        if (restart) begin
            clear_parser();
        end
        if (!header_closed) begin
            for (i = 0; i < 8; i++) begin
                if (!header_closed) begin
                    stg = (parse_stage < KIND_TRUNC) ? parse_stage : KIND_LENGTH;
                    wid = FIELD_WIDTH[stg];
                    field_bits = field_bits | (5'(data[i]) << bits_taken);
                    bits_taken++;
                    bit_pos++;
                    if (bits_taken >= wid) begin
                        if (stg == KIND_BTYPE && field_bits != BTYPE_DYNAMIC) begin
                            // Stored or fixed block: the header ends here.
                            add_expected(KIND_BTYPE, field_bits, '0, '0, 1'b1, 1'b1, bit_pos);
                            header_closed = 1'b1;
                        end else if (stg < KIND_LENGTH) begin
                            add_expected(stg, field_bits, '0, '0, 1'b0, 1'b0, '0);
                            if (stg == KIND_HCLEN) begin
                                hclen_raw = field_bits[3:0];
                            end
                            parse_stage = stg + 3'd1;
                        end else begin
                            pos = (lengths_done < 5'd19) ? lengths_done : 5'd18;
                            last_len = (int'(lengths_done) + 1 >= int'(hclen_raw) + 4);
                            add_expected(KIND_LENGTH, field_bits, SYMBOL_ORDER[pos], pos,
                                         last_len, 1'b0, last_len ? bit_pos : 7'd0);
                            lengths_done++;
                            if (last_len) begin
                                header_closed = 1'b1;
                            end
                        end
                        field_bits = '0;
                        bits_taken = '0;
                    end
                end
            end
            // Stream ran out before the header was complete.
            if (at_end && !header_closed) begin
                add_expected(KIND_TRUNC, field_bits, '0, '0, 1'b0, 1'b0, '0);
                header_closed = 1'b1;
            end
        end
        if (expected_fields.size() > first) begin
            expected_fields[expected_fields.size() - 1].last = 1'b1;
        end
    endtask

    task automatic check_field();
        t_hdr_result want;
        if (expected_fields.size() == 0) begin
            report_mismatch($sformatf("unexpected field kind %0d value %0d",
                                      i_m_tuser, i_m_tdata[4:0]));
        end else begin
            want = expected_fields.pop_front();
            if (i_m_tuser != want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", i_m_tuser, want.kind));
            if (i_m_tdata[4:0] != want.value)
                report_mismatch($sformatf("value %0d, want %0d", i_m_tdata[4:0], want.value));
            if (i_m_tdata[9:5] != want.symbol)
                report_mismatch($sformatf("symbol %0d, want %0d", i_m_tdata[9:5],
                                          want.symbol));
            if (i_m_tdata[14:10] != want.position)
                report_mismatch($sformatf("position %0d, want %0d", i_m_tdata[14:10],
                                          want.position));
            if (i_m_tdata[15] != want.header_done)
                report_mismatch($sformatf("header_done %0d, want %0d", i_m_tdata[15],
                                          want.header_done));
            if (i_m_tdata[16] != want.not_dynamic)
                report_mismatch($sformatf("not_dynamic %0d, want %0d", i_m_tdata[16],
                                          want.not_dynamic));
            if (i_m_tdata[23:17] != want.end_offset)
                report_mismatch($sformatf("end offset %0d, want %0d", i_m_tdata[23:17],
                                          want.end_offset));
            if (i_m_tlast != want.last)
                report_mismatch($sformatf("last %0d, want %0d", i_m_tlast, want.last));
        end
    endtask

    // Bytes are decoded before fields are checked, so a field taken in the
    // same cycle as a byte still meets its own expectation at the front.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            expected_fields.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                decode_header_byte(i_s_tdata, i_s_tuser[0], i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_field();
            end
        end
        pending_total = expected_fields.size();
    end

endmodule

>>> dv/deflate_dynamic_header_parser_test.sv
// ----------------------------------------------------------------------------
// DEFLATE header parser testbench
// Feeds directed and random DEFLATE block headers, whole, cut short and
// broken by restarts, through the parser under several idle and stall
// patterns; a checker beside the parser predicts and compares every field.
// ----------------------------------------------------------------------------
module deflate_dynamic_header_parser_test;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int ITEM_TARGET   = 370;
    localparam int SETTLE_CYCLES = 16;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;
    wire  [2:0]  m_tuser;
    wire         m_tlast;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int cycle_count   = 0;
    int phase;

    deflate_dynamic_header_parser dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    hdp_field_checker u_field_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Field receiver, stalling at the rate of the current phase.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one byte request, with random idle cycles ahead of it, and
    // return right after the edge that takes it.
    task automatic send_byte(input logic [7:0] data, input logic restart,
                             input logic at_end, input bit counted);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= restart;
        s_tlast  <= at_end;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (counted) items_sent++;
    endtask

    // Hold the byte stream off until every field has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One header with random content, mostly dynamic. Some are cut short by
    // end of stream, some are abandoned for the next restart, and some are
    // followed by bytes the parser should drop.
    task automatic send_random_header();
        logic [79:0] stream_bits;
        logic [3:0]  code_count;
        logic        close;
        logic        fresh;
        int          header_bits;
        int          byte_count;
        int          sent_count;
        int          shape;
        int          k;
        stream_bits = {16'($urandom), $urandom, $urandom};
        if ($urandom_range(9) != 0) stream_bits[2:1] = 2'b10;
        code_count  = stream_bits[16:13];
        header_bits = (stream_bits[2:1] == 2'b10) ? 17 + 3 * (int'(code_count) + 4) : 3;
        byte_count  = (header_bits + 7) / 8;
        shape       = $urandom_range(99);
        sent_count  = (shape < 20) ? $urandom_range(byte_count, 1) : byte_count;
        fresh       = ($urandom_range(19) != 0);
        for (k = 0; k < sent_count; k++) begin
            close = (k == sent_count - 1) &&
                    ((shape < 12) || (shape >= 20 && $urandom_range(7) == 0));
            send_byte(stream_bits[8 * k +: 8], (k == 0) && fresh, close, 1'b1);
        end
        if (shape >= 20 && $urandom_range(3) == 0) begin
            repeat ($urandom_range(2, 1)) begin
                send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b0);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: stored block straight after reset, then a dropped byte.
        send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b1, 1'b0);
        // Fixed and reserved block types.
        send_byte(8'h03, 1'b1, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1, 1'b0);
        // Largest header: all nineteen lengths, every field at its maximum.
        send_byte(8'hFD, 1'b1, 1'b0, 1'b0);
        repeat (8) send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1, 1'b0);
        // Smallest header: four zero lengths, all other fields zero.
        send_byte(8'h04, 1'b1, 1'b0, 1'b0);
        repeat (3) send_byte(8'h00, 1'b0, 1'b0, 1'b0);
        // End of stream on a field boundary: truncated with no bits.
        send_byte(8'h04, 1'b1, 1'b1, 1'b0);
        send_byte(8'h77, 1'b0, 1'b0, 1'b0);
        // End of stream partway into HCLEN.
        send_byte(8'hFD, 1'b1, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1, 1'b0);
        // Restart in the middle of a header.
        send_byte(8'hFD, 1'b1, 1'b0, 1'b0);
        send_byte(8'h05, 1'b1, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b1, 1'b0);
        wait_drained();

        // Random headers and noise bytes over the idle patterns.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 73;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 73;
                end
                default: begin
                    send_idle_pct = 22;
                    stall_pct     = 22;
                end
            endcase
            while (items_sent < ITEM_TARGET * (phase + 1) / 4) begin
                if ($urandom_range(99) < 8) begin
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                              ($urandom_range(4) == 0), 1'b1);
                end else begin
                    send_random_header();
                end
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/hdp_pkg.sv
rtl/hdp_byte_step.sv
rtl/hdp_out_buf.sv
rtl/deflate_dynamic_header_parser.sv
dv/hdp_field_checker.sv
dv/deflate_dynamic_header_parser_test.sv
